[rtl/core/sfo_pkg.sv]
// shared types, constants and saturating helpers for the spherical fold
`timescale 1ns / 1ps
package sfo_pkg;

  localparam int FRACTION_BITS_DEF  = 16;
  localparam int ITERATION_BITS_DEF = 8;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE_FLAGS = 3'd0,
    CFG_OUTER_OFFSET = 3'd1,
    CFG_INNER_OFFSET = 3'd2,
    CFG_ITER_WINDOWS = 3'd3,
    CFG_MIN_RADIUS   = 3'd4,
    CFG_MAX_RADIUS   = 3'd5,
    CFG_DE_SCALE     = 3'd6,
    CFG_DE_OFFSET    = 3'd7
  } cfg_index_t;

  // enable flag bit positions
  localparam int FLAG_SUB_OUTER  = 0;
  localparam int FLAG_ADD_OUTER  = 1;
  localparam int FLAG_SUB_INNER  = 2;
  localparam int FLAG_ADD_INNER  = 3;
  localparam int FLAG_SIGN_OUTER = 4;
  localparam int FLAG_SIGN_INNER = 5;
  localparam int FLAG_DE_RESCALE = 6;

  typedef enum logic [1:0] {
    FC_NONE   = 2'd0,
    FC_INNER  = 2'd1,
    FC_INVERT = 2'd2
  } fold_case_t;

  typedef struct packed {
    logic [3:0][31:0] z;
    logic [3:0][31:0] ov;
    logic [3:0][31:0] iv;
    logic [31:0]      de;
  } sfo_pay_t;

  typedef struct packed {
    fold_case_t fc;
    logic       zero;
  } sfo_ctl_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return s[31:0];
  endfunction

  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return s[31:0];
  endfunction

endpackage

[rtl/core/spherical_fold_with_offsets.sv]
// throughput: one item per cycle while the output is not stalled, set by the one-bit-per-stage divider pipeline
// the whole pipeline advances when the output register is empty or taken
// reset: synchronous, clears valid bits and loads the configuration defaults
// top level: configuration registers, stream ports and the three pipeline parts
`timescale 1ns / 1ps
module spherical_fold_with_offsets #(
  parameter int FRACTION_BITS  = sfo_pkg::FRACTION_BITS_DEF,
  parameter int ITERATION_BITS = sfo_pkg::ITERATION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // point_x, point_y, point_z, point_w, de_in, iteration
  input  logic [167:0]                   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // fold_x, fold_y, fold_z, fold_w, de_out, fold_case, zero fill
  output logic [167:0]                   m_tdata,
  input  logic                           cfg_we,
  input  logic [sfo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_wdata
);
  import sfo_pkg::*;

  logic [6:0]  enable_flags;
  logic [63:0] outer_offset, inner_offset;
  logic [31:0] iteration_windows, min_radius_sq, max_radius_sq, de_scale, de_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_flags      <= 7'd3;
      outer_offset      <= '0;
      inner_offset      <= '0;
      iteration_windows <= 32'hFF00_FF00;
      min_radius_sq     <= 32'h0000_4000;
      max_radius_sq     <= 32'h0001_0000;
      de_scale          <= 32'h0001_0000;
      de_offset         <= '0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_ENABLE_FLAGS: enable_flags      <= cfg_wdata[6:0];
        CFG_OUTER_OFFSET: outer_offset      <= cfg_wdata;
        CFG_INNER_OFFSET: inner_offset      <= cfg_wdata;
        CFG_ITER_WINDOWS: iteration_windows <= cfg_wdata[31:0];
        CFG_MIN_RADIUS:   min_radius_sq     <= cfg_wdata[31:0];
        CFG_MAX_RADIUS:   max_radius_sq     <= cfg_wdata[31:0];
        CFG_DE_SCALE:     de_scale          <= cfg_wdata[31:0];
        CFG_DE_OFFSET:    de_offset         <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  logic                        pre_valid, div_valid;
  sfo_pay_t                    pre_pay, div_pay;
  sfo_ctl_t                    pre_ctl, div_ctl;
  logic [32+FRACTION_BITS-1:0] pre_dividend;
  logic [31:0]                 pre_divisor, div_scale;
  logic [3:0][31:0]            fold;
  logic [31:0]                 de_out;
  fold_case_t                  fc;

  sfo_pre #(
    .FRACTION_BITS(FRACTION_BITS),
    .ITERATION_BITS(ITERATION_BITS)
  ) u_pre (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(s_tvalid),
    .in_point(s_tdata[127:0]),
    .in_de(s_tdata[159:128]),
    .in_iter(s_tdata[167:160]),
    .flags(enable_flags),
    .outer_offset(outer_offset),
    .inner_offset(inner_offset),
    .windows(iteration_windows),
    .min_radius_sq(min_radius_sq),
    .max_radius_sq(max_radius_sq),
    .out_valid(pre_valid),
    .out_pay(pre_pay),
    .out_ctl(pre_ctl),
    .out_dividend(pre_dividend),
    .out_divisor(pre_divisor)
  );

  sfo_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(pre_valid),
    .in_pay(pre_pay),
    .in_ctl(pre_ctl),
    .in_dividend(pre_dividend),
    .in_divisor(pre_divisor),
    .out_valid(div_valid),
    .out_pay(div_pay),
    .out_ctl(div_ctl),
    .out_scale(div_scale)
  );

  sfo_post #(.FRACTION_BITS(FRACTION_BITS)) u_post (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(div_valid),
    .in_pay(div_pay),
    .in_ctl(div_ctl),
    .in_scale(div_scale),
    .flags(enable_flags),
    .de_scale(de_scale),
    .de_offset(de_offset),
    .out_valid(m_tvalid),
    .out_fold(fold),
    .out_de(de_out),
    .out_fc(fc)
  );

  assign m_tdata = {6'd0, fc, de_out, fold};

endmodule

[rtl/core/sfo_pre.sv]
// offsets, squared radius and fold case selection, five stages
`timescale 1ns / 1ps
module sfo_pre #(
  parameter int FRACTION_BITS  = sfo_pkg::FRACTION_BITS_DEF,
  parameter int ITERATION_BITS = sfo_pkg::ITERATION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [3:0][31:0]          in_point,
  input  logic [31:0]               in_de,
  input  logic [7:0]                in_iter,
  input  logic [6:0]                flags,
  input  logic [63:0]               outer_offset,
  input  logic [63:0]               inner_offset,
  input  logic [31:0]               windows,
  input  logic [31:0]               min_radius_sq,
  input  logic [31:0]               max_radius_sq,
  output logic                      out_valid,
  output sfo_pkg::sfo_pay_t         out_pay,
  output sfo_pkg::sfo_ctl_t         out_ctl,
  output logic [32+FRACTION_BITS-1:0] out_dividend,
  output logic [31:0]               out_divisor
);
  import sfo_pkg::*;

  localparam logic [7:0] ItMask =
    (ITERATION_BITS >= 8) ? 8'hFF : 8'((1 << ITERATION_BITS) - 1);

  logic [7:0]  it;
  logic        oact, iact;
  sfo_pay_t    pay_s1;
  logic [31:0] ovc, ivc;

  logic        v1, v2, v3, v4;
  sfo_pay_t    pay1, pay2, pay3, pay4;
  logic [3:0][63:0] sq;
  logic [64:0] s01, s23;
  logic [63:0] rr;
  logic [65:0] tot;
  logic [3:0][31:0] z2_next;
  logic [3:0][63:0] sq_next;
  logic [31:0] mag;

  // stage 1: offsets inside their windows, mirror, outer subtract
  always_comb begin
    it   = in_iter & ItMask;
    oact = (it >= windows[7:0]) && (it < windows[15:8]);
    iact = (it >= windows[23:16]) && (it < windows[31:24]);
    pay_s1.de = in_de;
    for (int k = 0; k < 4; k++) begin
      ovc = oact ? (32'($signed(outer_offset[16*k +: 16])) <<< (FRACTION_BITS - 8)) : '0;
      ivc = iact ? (32'($signed(inner_offset[16*k +: 16])) <<< (FRACTION_BITS - 8)) : '0;
      if (flags[FLAG_SIGN_OUTER]) begin
        if (in_point[k] == '0) ovc = '0;
        else if (in_point[k][31]) ovc = -ovc;
      end
      if (flags[FLAG_SIGN_INNER]) begin
        if (in_point[k] == '0) ivc = '0;
        else if (in_point[k][31]) ivc = -ivc;
      end
      pay_s1.ov[k] = ovc;
      pay_s1.iv[k] = ivc;
      pay_s1.z[k]  = flags[FLAG_SUB_OUTER] ? sat_sub(in_point[k], ovc) : in_point[k];
    end
  end

  // stage 2: squares, inner subtract
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag        = pay1.z[k][31] ? (~pay1.z[k] + 32'd1) : pay1.z[k];
      sq_next[k] = 64'(mag) * 64'(mag);
      z2_next[k] = flags[FLAG_SUB_INNER] ? sat_sub(pay1.z[k], pay1.iv[k]) : pay1.z[k];
    end
  end

  assign tot = 66'(s01) + 66'(s23);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pay1   <= pay_s1;
      pay2   <= '{z: z2_next, ov: pay1.ov, iv: pay1.iv, de: pay1.de};
      sq     <= sq_next;
      pay3   <= pay2;
      s01    <= 65'(sq[0]) + 65'(sq[1]);
      s23    <= 65'(sq[2]) + 65'(sq[3]);
      pay4   <= pay3;
      rr     <= (tot[65:64] != 2'b00) ? '1 : tot[63:0];
    end
  end

  // stage 5: compare against the radii and pick the divisor
  logic [63:0] min_sh, max_sh;
  sfo_ctl_t    ctl_next;
  logic [31:0] dsr_next;

  always_comb begin
    min_sh = 64'(min_radius_sq) << FRACTION_BITS;
    max_sh = 64'(max_radius_sq) << FRACTION_BITS;
    ctl_next.fc   = FC_NONE;
    ctl_next.zero = 1'b0;
    dsr_next      = min_radius_sq;
    if (rr < min_sh) begin
      ctl_next.fc = FC_INNER;
    end else if (rr < max_sh) begin
      ctl_next.fc   = FC_INVERT;
      dsr_next      = 32'(rr >> FRACTION_BITS);
      ctl_next.zero = (dsr_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pay      <= pay4;
      out_ctl      <= ctl_next;
      out_divisor  <= dsr_next;
      out_dividend <= {max_radius_sq, {FRACTION_BITS{1'b0}}};
    end
  end

endmodule

[rtl/core/sfo_div.sv]
// restoring divider, one quotient bit per pipeline stage
`timescale 1ns / 1ps
module sfo_div #(
  parameter int FRACTION_BITS = sfo_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  sfo_pkg::sfo_pay_t           in_pay,
  input  sfo_pkg::sfo_ctl_t           in_ctl,
  input  logic [32+FRACTION_BITS-1:0] in_dividend,
  input  logic [31:0]                 in_divisor,
  output logic                        out_valid,
  output sfo_pkg::sfo_pay_t           out_pay,
  output sfo_pkg::sfo_ctl_t           out_ctl,
  output logic [31:0]                 out_scale
);
  import sfo_pkg::*;

  localparam int DvdW = 32 + FRACTION_BITS;

  logic            vld [DvdW];
  logic [31:0]     rem [DvdW];
  logic [DvdW-1:0] quo [DvdW];
  logic [DvdW-1:0] dvd [DvdW];
  logic [31:0]     dsr [DvdW];
  sfo_pay_t        pay [DvdW];
  sfo_ctl_t        ctl [DvdW];

  for (genvar i = 0; i < DvdW; i++) begin : g_stage
    logic            p_vld;
    logic [31:0]     p_rem;
    logic [DvdW-1:0] p_quo, p_dvd;
    logic [31:0]     p_dsr;
    sfo_pay_t        p_pay;
    sfo_ctl_t        p_ctl;
    logic [32:0]     trial;
    logic            ge;

    if (i == 0) begin : g_first
      assign p_vld = in_valid;
      assign p_rem = '0;
      assign p_quo = '0;
      assign p_dvd = in_dividend;
      assign p_dsr = in_divisor;
      assign p_pay = in_pay;
      assign p_ctl = in_ctl;
    end else begin : g_next
      assign p_vld = vld[i-1];
      assign p_rem = rem[i-1];
      assign p_quo = quo[i-1];
      assign p_dvd = dvd[i-1];
      assign p_dsr = dsr[i-1];
      assign p_pay = pay[i-1];
      assign p_ctl = ctl[i-1];
    end

    assign trial = {p_rem, p_dvd[DvdW-1]};
    assign ge    = trial >= {1'b0, p_dsr};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i] <= ge ? 32'(trial - {1'b0, p_dsr}) : trial[31:0];
        quo[i] <= {p_quo[DvdW-2:0], ge};
        dvd[i] <= p_dvd << 1;
        dsr[i] <= p_dsr;
        pay[i] <= p_pay;
        ctl[i] <= p_ctl;
      end
    end
  end

  // quotient saturates to 32 bits, a zero divisor saturates too
  assign out_valid = vld[DvdW-1];
  assign out_pay   = pay[DvdW-1];
  assign out_ctl   = ctl[DvdW-1];
  assign out_scale = (ctl[DvdW-1].zero || (quo[DvdW-1][DvdW-1:32] != '0))
                     ? '1 : quo[DvdW-1][31:0];

endmodule

[rtl/core/sfo_post.sv]
// scaling of point and de, offsets added back, de rescale, output register
`timescale 1ns / 1ps
module sfo_post #(
  parameter int FRACTION_BITS = sfo_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  sfo_pkg::sfo_pay_t in_pay,
  input  sfo_pkg::sfo_ctl_t in_ctl,
  input  logic [31:0]       in_scale,
  input  logic [6:0]        flags,
  input  logic [31:0]       de_scale,
  input  logic [31:0]       de_offset,
  output logic              out_valid,
  output logic [3:0][31:0]  out_fold,
  output logic [31:0]       out_de,
  output sfo_pkg::fold_case_t out_fc
);
  import sfo_pkg::*;

  logic             v1, v2, v3;
  sfo_pay_t         pay1;
  sfo_ctl_t         ctl1, ctl2, ctl3;
  logic [3:0][63:0] prod, prod_next;
  logic [3:0]       neg;
  logic [63:0]      pde;
  logic [3:0][31:0] z2, z2_next, z3;
  logic [31:0]      de2, de2_next, de3;
  logic [63:0]      pr;
  logic [31:0]      mag;
  logic [63:0]      p;
  logic [31:0]      zc;
  logic [63:0]      pd;

  // stage 1: magnitudes times the scale
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag          = in_pay.z[k][31] ? (~in_pay.z[k] + 32'd1) : in_pay.z[k];
      prod_next[k] = 64'(mag) * 64'(in_scale);
    end
  end

  // stage 2: truncate, restore sign, saturate, add offsets back, truncate and clamp the scaled de
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      p  = prod[k] >> FRACTION_BITS;
      zc = pay1.z[k];
      if (ctl1.fc != FC_NONE) begin
        if (neg[k]) zc = (p >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-p);
        else        zc = (p > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : p[31:0];
      end
      if (flags[FLAG_ADD_OUTER]) zc = sat_add(zc, pay1.ov[k]);
      if (flags[FLAG_ADD_INNER]) zc = sat_add(zc, pay1.iv[k]);
      z2_next[k] = zc;
    end
    pd       = pde >> FRACTION_BITS;
    de2_next = pay1.de;
    if (ctl1.fc != FC_NONE) de2_next = (pd[63:32] != '0) ? '1 : pd[31:0];
  end

  // stage 4: affine de rescale with clamp to the unsigned range
  logic [63:0] q;
  logic [65:0] dsum;
  logic [31:0] de4_next;

  always_comb begin
    q        = pr >> FRACTION_BITS;
    dsum     = {2'b00, q} + 66'($signed(de_offset));
    de4_next = de3;
    if (flags[FLAG_DE_RESCALE]) begin
      if (dsum[65])                 de4_next = '0;
      else if (dsum[64:32] != '0)   de4_next = '1;
      else                          de4_next = dsum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod     <= prod_next;
      pde      <= 64'(in_pay.de) * 64'(in_scale);
      for (int k = 0; k < 4; k++) neg[k] <= in_pay.z[k][31];
      pay1     <= in_pay;
      ctl1     <= in_ctl;
      z2       <= z2_next;
      de2      <= de2_next;
      ctl2     <= ctl1;
      z3       <= z2;
      de3      <= de2;
      pr       <= 64'(de2) * 64'(de_scale);
      ctl3     <= ctl2;
      out_fold <= z3;
      out_de   <= de4_next;
      out_fc   <= ctl3.fc;
    end
  end

endmodule

[bench/tb_spherical_fold_with_offsets.sv]
// self-checking bench for the spherical fold with outer and inner offsets
`timescale 1ns / 1ps
module tb_spherical_fold_with_offsets;
  import sfo_pkg::*;

  typedef struct {
    logic [31:0] p [4];
    logic [31:0] de;
    logic [7:0]  iter;
  } point_item_t;

  typedef struct {
    logic [31:0] f [4];
    logic [31:0] de;
    logic [1:0]  fc;
  } fold_item_t;

  localparam int FB = 16;
  localparam int LATENCY = 9 + 32 + FB;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [167:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [167:0] m_tdata;
  logic         cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]  cfg_wdata = '0;

  // predictor copy of the registers
  logic [6:0]   r_flags;
  logic [63:0]  r_outer, r_inner;
  logic [31:0]  r_win, r_min, r_max, r_dscale;
  logic signed [31:0] r_doff;

  point_item_t  pending_points [$];
  fold_item_t   expected_folds [$];
  int           send_idle_pct = 0, recv_stall_pct = 0;
  int           mismatches = 0;
  longint       cycles = 0;

  spherical_fold_with_offsets i_dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd2_000_000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint scale_signed(longint v, logic [63:0] m);
    logic [63:0] mag, pr;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    pr = (mag * m) >> FB;
    return sat_s32((v < 0) ? -longint'(pr) : longint'(pr));
  endfunction

  function automatic fold_item_t fold_point(point_item_t it);
    fold_item_t r;
    longint z [4], ov [4], iv [4], sg;
    logic oact, iact;
    logic [63:0] de, rr, sq, mag, m, maxs, r2;
    logic [1:0] fc;
    oact = it.iter >= r_win[7:0] && it.iter < r_win[15:8];
    iact = it.iter >= r_win[23:16] && it.iter < r_win[31:24];
    de = {32'b0, it.de};
    rr = 0;
    m = 0;
    fc = FC_NONE;
    for (int k = 0; k < 4; k++) begin
      z[k] = longint'(signed'(it.p[k]));
      sg = z[k] > 0 ? 1 : (z[k] < 0 ? -1 : 0);
      ov[k] = oact ? longint'(signed'(r_outer[16*k +: 16])) * 256 : 0;
      iv[k] = iact ? longint'(signed'(r_inner[16*k +: 16])) * 256 : 0;
      if (r_flags[FLAG_SIGN_OUTER]) ov[k] = ov[k] * sg;
      if (r_flags[FLAG_SIGN_INNER]) iv[k] = iv[k] * sg;
      if (r_flags[FLAG_SUB_OUTER]) z[k] = sat_s32(z[k] - ov[k]);
    end
    for (int k = 0; k < 4; k++) begin
      mag = z[k] < 0 ? 64'(-z[k]) : 64'(z[k]);
      sq = mag * mag;
      rr = (rr > ~64'd0 - sq) ? ~64'd0 : rr + sq;
      if (r_flags[FLAG_SUB_INNER]) z[k] = sat_s32(z[k] - iv[k]);
    end
    maxs = {32'b0, r_max} << FB;
    if (rr < ({32'b0, r_min} << FB)) begin
      fc = FC_INNER;
      m = maxs / r_min;
    end else if (rr < maxs) begin
      fc = FC_INVERT;
      r2 = rr >> FB;
      m = (r2 == 0) ? 64'hFFFF_FFFF : maxs / r2;
    end
    if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
    if (fc != FC_NONE) begin
      for (int k = 0; k < 4; k++) z[k] = scale_signed(z[k], m);
      de = (de * m) >> FB;
      if (de > 64'hFFFF_FFFF) de = 64'hFFFF_FFFF;
    end
    for (int k = 0; k < 4; k++) begin
      if (r_flags[FLAG_ADD_OUTER]) z[k] = sat_s32(z[k] + ov[k]);
      if (r_flags[FLAG_ADD_INNER]) z[k] = sat_s32(z[k] + iv[k]);
    end
    if (r_flags[FLAG_DE_RESCALE]) begin
      longint d;
      d = longint'((de * r_dscale) >> FB) + longint'(r_doff);
      if (d < 0) d = 0;
      de = (d > 64'sh FFFF_FFFF) ? 64'hFFFF_FFFF : 64'(d);
    end
    for (int k = 0; k < 4; k++) r.f[k] = z[k][31:0];
    r.de = de[31:0];
    r.fc = fc;
    return r;
  endfunction

  // driver: s_tvalid held until accepted, next item loaded in the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (!s_tvalid || s_tready) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          point_item_t it;
          it = pending_points.pop_front();
          expected_folds.push_back(fold_point(it));
          s_tdata <= {it.iter, it.de, it.p[3], it.p[2], it.p[1], it.p[0]};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_tvalid && m_tready) begin
        fold_item_t got, exp_f;
        for (int k = 0; k < 4; k++) got.f[k] = m_tdata[32*k +: 32];
        got.de = m_tdata[159:128];
        got.fc = m_tdata[161:160];
        if (expected_folds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item %h", m_tdata);
        end else begin
          exp_f = expected_folds.pop_front();
          if (got.f != exp_f.f || got.de != exp_f.de || got.fc != exp_f.fc) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h %h %h %h de %h fc %0d / got %h %h %h %h de %h fc %0d",
                exp_f.f[0], exp_f.f[1], exp_f.f[2], exp_f.f[3], exp_f.de, exp_f.fc,
                got.f[0], got.f[1], got.f[2], got.f[3], got.de, got.fc);
          end
        end
      end
    end
  end

  task automatic write_reg(cfg_index_t idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ENABLE_FLAGS: r_flags = val[6:0];
      CFG_OUTER_OFFSET: r_outer = val;
      CFG_INNER_OFFSET: r_inner = val;
      CFG_ITER_WINDOWS: r_win = val[31:0];
      CFG_MIN_RADIUS:   r_min = val[31:0];
      CFG_MAX_RADIUS:   r_max = val[31:0];
      CFG_DE_SCALE:     r_dscale = val[31:0];
      CFG_DE_OFFSET:    r_doff = val[31:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_points.size() > 0 || expected_folds.size() > 0 || s_tvalid)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_comp(int scale_sel);
    case (scale_sel)
      0: return $urandom;
      1: return 32'($signed($urandom_range(131072)) - 65536);
      2: return 32'($signed($urandom_range(600000)) - 300000);
      default: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return 32'($signed($urandom_range(4000)) - 2000);
        endcase
      end
    endcase
  endfunction

  task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w,
                           logic [31:0] de, logic [7:0] iter);
    point_item_t it;
    it.p[0] = x; it.p[1] = y; it.p[2] = z; it.p[3] = w;
    it.de = de;
    it.iter = iter;
    pending_points.push_back(it);
  endtask

  task automatic add_random(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(3);
      add_point(rand_comp(sel), rand_comp(sel), rand_comp(sel), rand_comp(sel),
                $urandom_range(3) == 0 ? $urandom : $urandom_range(262144),
                8'($urandom_range(255)));
    end
  endtask

  task automatic random_config;
    write_reg(CFG_ENABLE_FLAGS, 64'($urandom_range(127)));
    write_reg(CFG_OUTER_OFFSET, {$urandom, $urandom});
    write_reg(CFG_INNER_OFFSET, {$urandom, $urandom});
    write_reg(CFG_ITER_WINDOWS, 64'({8'($urandom_range(255)), 8'($urandom_range(64)),
                                     8'($urandom_range(255)), 8'($urandom_range(64))}));
    write_reg(CFG_MIN_RADIUS, 64'($urandom_range(1, 65536)));
    write_reg(CFG_MAX_RADIUS,
              64'($urandom_range(1, 4) == 1 ? $urandom : $urandom_range(1, 262144)));
    write_reg(CFG_DE_SCALE, 64'($urandom_range(1) ? $urandom : $urandom_range(200000)));
    write_reg(CFG_DE_OFFSET, 64'($urandom));
  endtask

  initial begin
    r_flags = 7'd3; r_outer = '0; r_inner = '0; r_win = 32'hFF00_FF00;
    r_min = 32'h4000; r_max = 32'h10000; r_dscale = 32'h10000; r_doff = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, then all flags with large offsets, then extreme radii
    add_point(0, 0, 0, 0, 32'h10000, 0);
    add_point(32'h2000, 0, 0, 0, 32'h10000, 1);
    add_point(32'h8000, 32'h8000, 0, 0, 32'hFFFF_FFFF, 2);
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 255);
    add_point(32'h1, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 3);
    add_point(32'h20000, 0, 0, 0, 32'h10000, 4);
    drain();
    write_reg(CFG_ENABLE_FLAGS, 64'h7F);
    write_reg(CFG_OUTER_OFFSET, 64'h7FFF_8000_0100_FF00);
    write_reg(CFG_INNER_OFFSET, 64'h8000_7FFF_FF00_0080);
    write_reg(CFG_ITER_WINDOWS, 64'h0A02_0800);
    write_reg(CFG_DE_SCALE, 64'hFFFF_FFFF);
    write_reg(CFG_DE_OFFSET, 64'h8000_0000);
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h100, 32'h10000, 1);
    add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h4000, 0, 32'hFFFF_FFFF, 2);
    add_point(32'h100, 32'hFFFF_FF00, 32'h100, 0, 32'h1234, 5);
    add_point(0, 0, 0, 0, 32'h8000, 9);
    add_point(32'h4000, 32'h4000, 32'h4000, 32'h4000, 32'h10000, 200);
    drain();
    write_reg(CFG_MIN_RADIUS, 0);
    write_reg(CFG_MAX_RADIUS, 64'hFFFF_FFFF);
    write_reg(CFG_DE_OFFSET, 64'h7FFF_FFFF);
    add_point(0, 0, 0, 0, 32'h10000, 0);
    add_point(32'h10, 0, 0, 0, 32'h10000, 0);
    add_point(32'h100, 32'h100, 0, 0, 32'hFFFF_FFFF, 3);
    add_point(32'h7FFF_FFFF, 0, 0, 0, 32'h10000, 7);
    drain();

    // random phases, idling pattern rotates
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      random_config();
      add_random(75);
      drain();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
